/* rtl/vlbs_pkg.sv */
package vlbs_pkg;

    localparam int CAPACITY       = 1024;
    localparam int MAX_ELEM_BYTES = 8;
    localparam int HEADER_BYTES   = 4;

    localparam int BYTE_W   = 8;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int PTR_W    = ADDR_W + 1;
    localparam int OP_W     = 3;
    localparam int LEN_W    = 4;
    localparam int DATA_W   = 64;
    localparam int STATUS_W = 2;
    localparam int FREE_W   = 11;
    localparam int CNT_W    = $clog2(HEADER_BYTES + MAX_ELEM_BYTES);
    localparam int HIDX_W   = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
    localparam int DIDX_W   = $clog2(DATA_W / BYTE_W);

    typedef logic [OP_W-1:0]     t_op;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_op OP_PUSH  = 3'd0;
    localparam t_op OP_POP   = 3'd1;
    localparam t_op OP_PEEK  = 3'd2;
    localparam t_op OP_CLEAR = 3'd3;
    localparam t_op OP_QUERY = 3'd4;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] wdata;
    } t_ram_req;

    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] v);
        return (v > LEN_W'(MAX_ELEM_BYTES)) ? LEN_W'(MAX_ELEM_BYTES) : v;
    endfunction

endpackage

/* rtl/vlbs_if.sv */
interface vlbs_cmd_if import vlbs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [LEN_W-1:0]  length;
    logic [DATA_W-1:0] push_data;

    modport source (output valid, output opcode, output length, output push_data, input ready);
    modport sink   (input valid, input opcode, input length, input push_data, output ready);
endinterface

interface vlbs_rsp_if import vlbs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   read_data;
    logic [LEN_W-1:0]    read_length;
    logic                is_empty;
    logic                would_fit;
    logic [FREE_W-1:0]   free_bytes;

    modport source (output valid, output status, output read_data, output read_length,
                    output is_empty, output would_fit, output free_bytes, input ready);
    modport sink   (input valid, input status, input read_data, input read_length,
                    input is_empty, input would_fit, input free_bytes, output ready);
endinterface

/* rtl/vlbs_ram.sv */
module vlbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/vlbs_ctrl.sv */
module vlbs_ctrl import vlbs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    vlbs_cmd_if.sink          i_cmd,
    vlbs_rsp_if.source        o_rsp,
    output t_ram_req          o_ram_req,
    input  logic [BYTE_W-1:0] i_ram_rdata
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_PUSH_PTR = 8'b0000_0010,
        S_WRITE    = 8'b0000_0100,
        S_RD_HDR   = 8'b0000_1000,
        S_RD_LEN   = 8'b0001_0000,
        S_RD_DATA  = 8'b0010_0000,
        S_RD_END   = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    r_last;
    t_op                 r_op;
    logic [LEN_W-1:0]    r_len;
    logic [DATA_W-1:0]   r_pdata;
    logic [PTR_W-1:0]    r_top;
    t_status             r_status;
    logic [DATA_W-1:0]   r_rdata;
    logic [LEN_W-1:0]    r_n;
    logic [LEN_W-1:0]    r_stored;
    logic [BYTE_W-1:0]   r_hdr0;
    logic                r_hi_nz;
    logic                r_hv;
    logic [HIDX_W-1:0]   r_hidx;
    logic                r_dv;
    logic [DIDX_W-1:0]   r_didx;

    logic                r_o_valid;
    t_status             r_o_status;
    logic [DATA_W-1:0]   r_o_rdata;
    logic [LEN_W-1:0]    r_o_rlen;
    logic                r_o_empty;
    logic                r_o_fit;
    logic [FREE_W-1:0]   r_o_free;

    logic                accept;
    logic                load_out;
    logic [LEN_W-1:0]    len_in;
    logic                fits_in;
    logic                empty_now;
    logic [PTR_W-1:0]    add_b;
    logic [PTR_W-1:0]    sum;
    logic [DIDX_W-1:0]   byte_idx;
    logic [BYTE_W-1:0]   wr_byte;
    logic [BYTE_W-1:0]   hdr_lo;
    logic                hi_nz;
    logic [LEN_W-1:0]    stored;
    logic [LEN_W-1:0]    take;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign load_out    = (r_state == S_DONE) && (!r_o_valid || o_rsp.ready);
    assign len_in      = sat_len(i_cmd.length);
    assign fits_in     = r_top >= (PTR_W'(len_in) + PTR_W'(HEADER_BYTES));
    assign empty_now   = r_top >= PTR_W'(CAPACITY);

    // shared address and pointer adder
    always_comb begin
        add_b = '0;
        unique case (r_state) inside
            S_PUSH_PTR:                   add_b = ~(PTR_W'(r_len) + PTR_W'(HEADER_BYTES - 1));
            S_WRITE, S_RD_HDR, S_RD_DATA: add_b = PTR_W'(r_cnt);
            S_RD_END:                     add_b = PTR_W'(r_stored) + PTR_W'(HEADER_BYTES);
            default:                      add_b = '0;
        endcase
    end
    assign sum = r_top + add_b;

    assign byte_idx = DIDX_W'(r_cnt - CNT_W'(HEADER_BYTES));
    always_comb begin
        if (r_cnt < CNT_W'(HEADER_BYTES)) begin
            wr_byte = (r_cnt == '0) ? BYTE_W'(r_len) : '0;
        end else begin
            wr_byte = r_pdata[{byte_idx, 3'b000} +: BYTE_W];
        end
    end

    assign o_ram_req.we    = (r_state == S_WRITE);
    assign o_ram_req.addr  = sum[ADDR_W-1:0];
    assign o_ram_req.wdata = wr_byte;

    // header decode as the last header byte arrives
    assign hdr_lo = (r_hidx == '0) ? i_ram_rdata : r_hdr0;
    assign hi_nz  = r_hi_nz || ((r_hidx != '0) && (i_ram_rdata != '0));
    assign stored = (hi_nz || (hdr_lo > BYTE_W'(MAX_ELEM_BYTES)))
                    ? LEN_W'(MAX_ELEM_BYTES) : LEN_W'(hdr_lo);
    assign take   = (stored < r_len) ? stored : r_len;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_cmd.opcode) inside
                        OP_PUSH:          n_state = fits_in ? S_PUSH_PTR : S_DONE;
                        OP_POP, OP_PEEK:  n_state = empty_now ? S_DONE : S_RD_HDR;
                        default:          n_state = S_DONE;
                    endcase
                end
            end
            S_PUSH_PTR: n_state = S_WRITE;
            S_WRITE:    n_state = (r_cnt == r_last) ? S_DONE : S_WRITE;
            S_RD_HDR:   n_state = (r_cnt == CNT_W'(HEADER_BYTES - 1)) ? S_RD_LEN : S_RD_HDR;
            S_RD_LEN:   n_state = (take == '0) ? S_RD_END : S_RD_DATA;
            S_RD_DATA:  n_state = (r_cnt == r_last) ? S_RD_END : S_RD_DATA;
            S_RD_END:   n_state = S_DONE;
            S_DONE:     n_state = load_out ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_top     <= PTR_W'(CAPACITY);
            r_o_valid <= 1'b0;
            r_hv      <= 1'b0;
            r_dv      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hv    <= (r_state == S_RD_HDR);
            r_dv    <= (r_state == S_RD_DATA);
            r_hidx  <= r_cnt[HIDX_W-1:0];
            r_didx  <= byte_idx;

            if (r_hv) begin
                if (r_hidx == '0) begin
                    r_hdr0 <= i_ram_rdata;
                end else if (i_ram_rdata != '0) begin
                    r_hi_nz <= 1'b1;
                end
            end
            if (r_dv) begin
                r_rdata[{r_didx, 3'b000} +: BYTE_W] <= i_ram_rdata;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op     <= i_cmd.opcode;
                        r_len    <= len_in;
                        r_pdata  <= i_cmd.push_data;
                        r_cnt    <= '0;
                        r_last   <= CNT_W'(len_in) + CNT_W'(HEADER_BYTES - 1);
                        r_rdata  <= '0;
                        r_n      <= '0;
                        r_hi_nz  <= 1'b0;
                        r_status <= ST_OK;
                        unique case (i_cmd.opcode) inside
                            OP_PUSH: begin
                                if (!fits_in) begin
                                    r_status <= ST_FULL;
                                end
                            end
                            OP_POP, OP_PEEK: begin
                                if (empty_now) begin
                                    r_status <= ST_EMPTY;
                                end
                            end
                            OP_CLEAR: r_top <= PTR_W'(CAPACITY);
                            default: ;
                        endcase
                    end
                end
                S_PUSH_PTR: r_top <= sum;
                S_WRITE, S_RD_HDR, S_RD_DATA: r_cnt <= r_cnt + CNT_W'(1);
                S_RD_LEN: begin
                    r_stored <= stored;
                    r_n      <= take;
                    r_last   <= CNT_W'(HEADER_BYTES) + CNT_W'(take) - CNT_W'(1);
                end
                S_RD_END: begin
                    if (r_op == OP_POP) begin
                        r_top <= (sum > PTR_W'(CAPACITY)) ? PTR_W'(CAPACITY) : sum;
                    end
                end
                S_DONE: ;
                default: ;
            endcase

            if (load_out) begin
                r_o_valid  <= 1'b1;
                r_o_status <= r_status;
                r_o_rdata  <= r_rdata;
                r_o_rlen   <= r_n;
                r_o_empty  <= empty_now;
                r_o_fit    <= r_top >= (PTR_W'(r_len) + PTR_W'(HEADER_BYTES));
                r_o_free   <= FREE_W'(r_top);
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.read_data   = r_o_rdata;
    assign o_rsp.read_length = r_o_rlen;
    assign o_rsp.is_empty    = r_o_empty;
    assign o_rsp.would_fit   = r_o_fit;
    assign o_rsp.free_bytes  = r_o_free;

endmodule

/* rtl/variable_length_byte_stack.sv */
// Downward-growing stack of 0 to 8 byte elements, each with a 4-byte little-endian
// length header, in a 1024-byte single-port store. One command transaction gives one
// response transaction. All bytes move through the one byte-wide store port, one per
// cycle. A push updates the pointer, then writes header and data bytes; a pop or peek
// reads 4 header bytes, decodes the length, reads data bytes and (pop only) updates the
// pointer. Clear, query, unknown opcodes, a push that does not fit and a pop or peek on
// an empty stack go to the response. A command is taken only when the previous one
// is finished; a response waiting in the output register does not stop the next command
// from starting, but that command cannot finish until the waiting response is taken.
module variable_length_byte_stack import vlbs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vlbs_cmd_if.sink   i_cmd,
    vlbs_rsp_if.source o_rsp
);

    t_ram_req          ram_req;
    logic [BYTE_W-1:0] ram_rdata;

    vlbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_rsp       (o_rsp),
        .o_ram_req   (ram_req),
        .i_ram_rdata (ram_rdata)
    );

    vlbs_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_addr  (ram_req.addr),
        .i_wdata (ram_req.wdata),
        .o_rdata (ram_rdata)
    );

endmodule

/* rtl/vlbs_chk.sv */
module vlbs_chk import vlbs_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_cmd_valid,
    input logic                i_cmd_ready,
    input logic                i_rsp_valid,
    input logic                i_rsp_ready,
    input logic [STATUS_W-1:0] i_rsp_status,
    input logic [DATA_W-1:0]   i_rsp_read_data,
    input logic [LEN_W-1:0]    i_rsp_read_length,
    input logic                i_rsp_is_empty,
    input logic [FREE_W-1:0]   i_rsp_free_bytes
);

    // response holds until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status)
            && $stable(i_rsp_read_data) && $stable(i_rsp_free_bytes))
        else $error("response changed while stalled");

    // one command in flight
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && i_cmd_ready |=> !i_cmd_ready)
        else $error("command taken while busy");

    a_empty_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp_is_empty == (i_rsp_free_bytes == FREE_W'(CAPACITY)))
        else $error("empty flag disagrees with free bytes");

    a_fail_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status != ST_OK) |->
            (i_rsp_read_length == '0) && (i_rsp_read_data == '0))
        else $error("failed transaction delivered data");

    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_read_length <= LEN_W'(MAX_ELEM_BYTES))
            && (i_rsp_free_bytes <= FREE_W'(CAPACITY)))
        else $error("response field out of range");

endmodule

bind variable_length_byte_stack vlbs_chk u_vlbs_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_cmd_valid       (i_cmd.valid),
    .i_cmd_ready       (i_cmd.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_status      (o_rsp.status),
    .i_rsp_read_data   (o_rsp.read_data),
    .i_rsp_read_length (o_rsp.read_length),
    .i_rsp_is_empty    (o_rsp.is_empty),
    .i_rsp_free_bytes  (o_rsp.free_bytes)
);
